// ===== rtl/core/ccts_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccts_pkg: shared types and constants
// Item structs, request codes, status codes and sequencer states for the
// CAN channel traffic statistics block.
// ----------------------------------------------------------------------------
package ccts_pkg;

	localparam int Channels     = 4;
	localparam int HistoryDepth = 10;
	localparam int ChW          = $clog2(Channels);
	localparam int PosW         = $clog2(HistoryDepth);
	localparam int FillW        = $clog2(HistoryDepth + 1);
	localparam int RingDepth    = Channels * HistoryDepth;
	localparam int SlotW        = $clog2(RingDepth);
	localparam int RateW        = 20;
	localparam logic [RateW-1:0] RateMax = '1;
	localparam logic [9:0]       MsPerSec = 10'd1000;

	typedef enum logic [2:0] {
		REQ_RECV    = 3'd0,
		REQ_DROP_RX = 3'd1,
		REQ_SEND    = 3'd2,
		REQ_DROP_TX = 3'd3,
		REQ_TICK    = 3'd4,
		REQ_READ    = 3'd5,
		REQ_HIST    = 3'd6,
		REQ_NONE    = 3'd7
	} req_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_BAD_CH  = 2'd1,
		ST_BAD_AGE = 2'd2,
		ST_RSVD    = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIV_RX,
		S_DIV_TX,
		S_APPLY,
		S_RING,
		S_OUT
	} state_t;

	typedef struct packed {
		logic [2:0]  req_type;
		logic [3:0]  channel;
		logic [31:0] msg_header;
		logic [63:0] msg_data;
		logic [31:0] drop_amount;
		logic [31:0] now_ms;
		logic [5:0]  history_age;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] recv_total;
		logic [31:0] recv_dropped;
		logic [31:0] send_total;
		logic [31:0] send_dropped;
		logic [19:0] recv_fps;
		logic [19:0] send_fps;
		logic [5:0]  history_fill;
		logic [31:0] hist_header;
		logic [63:0] hist_data;
	} out_item_t;

	typedef struct packed {
		logic start;
		logic busy;
		logic done;
	} div_ctl_t;

endpackage

// ===== rtl/core/can_channel_traffic_stats.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// can_channel_traffic_stats: per-channel CAN traffic statistics
// Input channel (in_valid/in_stall/in_item) takes one request item: a
// received message, a drop count, a send, a send drop, a rate tick, a
// counter read or a history read. Each item yields exactly one result item
// on the output channel (out_valid/out_stall/out_item) carrying the
// addressed channel's counters after the request was applied.
// Sequence: an accepted item passes through S_APPLY and S_RING, where the
// result is registered; S_OUT holds it until it is taken, then the sequencer
// returns to S_IDLE and the next item can be accepted.
// A rate tick also runs the shared serial divider twice per channel (start,
// 42 quotient bits, done), receive rate then send rate; when the elapsed
// time is zero the division is skipped and the rates are kept.
// One item is handled at a time; in_stall is high from acceptance until the
// sequencer is back in S_IDLE after the result has been taken. While out_stall is high the
// result holds.
// Reset clears all counters, rates, stamps, ring positions and fill counts;
// the history ring memory is not cleared, entries are read only after they
// were written.
// ----------------------------------------------------------------------------
module can_channel_traffic_stats (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  ccts_pkg::in_item_t  in_item,
	output logic                out_valid,
	input  logic                out_stall,
	output ccts_pkg::out_item_t out_item
);
	localparam int ChW   = ccts_pkg::ChW;
	localparam int PosW  = ccts_pkg::PosW;
	localparam int FillW = ccts_pkg::FillW;
	localparam int SlotW = ccts_pkg::SlotW;
	localparam int RateW = ccts_pkg::RateW;
	localparam int Ch    = ccts_pkg::Channels;
	localparam int Hd    = ccts_pkg::HistoryDepth;

	ccts_pkg::state_t   state_q, state_d;
	ccts_pkg::in_item_t req_q;
	ccts_pkg::out_item_t res_q;
	ccts_pkg::out_item_t res_d;
	logic               out_valid_q;

	logic [31:0] rx_count_q     [Ch];
	logic [31:0] rx_drop_q      [Ch];
	logic [31:0] tx_count_q     [Ch];
	logic [31:0] tx_drop_q      [Ch];
	logic [31:0] rx_window_q    [Ch];
	logic [31:0] tx_window_q    [Ch];
	logic [RateW-1:0] rx_rate_q [Ch];
	logic [RateW-1:0] tx_rate_q [Ch];
	logic [31:0] stamp_q        [Ch];
	logic [PosW-1:0] wpos_q     [Ch];
	logic [FillW-1:0] fill_q    [Ch];

	logic [31:0] ring_hdr_q [ccts_pkg::RingDepth];
	logic [63:0] ring_dat_q [ccts_pkg::RingDepth];
	logic [31:0] rd_hdr_q;
	logic [63:0] rd_dat_q;

	logic [ChW-1:0] tc_q;
	logic           ch_ok;
	logic [ChW-1:0] ch;
	logic [31:0]    elapsed;
	logic           div_start;
	logic [31:0]    div_win;
	ccts_pkg::div_ctl_t div_ctl;
	logic [RateW-1:0] div_rate;
	logic           age_bad;
	logic [PosW:0]  rd_pos_w;
	logic [PosW-1:0] rd_pos;
	logic [SlotW-1:0] wr_slot, rd_slot;
	logic           in_acc, out_acc;

	assign ch_ok   = (32'(req_q.channel) < 32'(Ch));
	assign ch      = req_q.channel[ChW-1:0];
	assign elapsed = req_q.now_ms - stamp_q[tc_q];
	assign div_win = (state_q == ccts_pkg::S_DIV_RX) ? rx_window_q[tc_q] : tx_window_q[tc_q];
	assign in_acc  = in_valid && !in_stall;
	assign out_acc = out_valid_q && !out_stall;
	assign in_stall  = (state_q != ccts_pkg::S_IDLE);
	assign out_valid = out_valid_q;
	assign out_item  = res_q;

	assign age_bad  = (7'(req_q.history_age) >= 7'(fill_q[ch])) ||
		(7'(req_q.history_age) >= 7'(Hd));
	assign rd_pos_w = (PosW+1)'(wpos_q[ch]) + (PosW+1)'(Hd - 1)
		- (PosW+1)'(req_q.history_age[PosW-1:0]);
	assign rd_pos   = (rd_pos_w >= (PosW+1)'(Hd)) ? PosW'(rd_pos_w - (PosW+1)'(Hd))
		: rd_pos_w[PosW-1:0];
	assign wr_slot  = SlotW'(ch) * SlotW'(Hd) + SlotW'(wpos_q[ch]);
	assign rd_slot  = SlotW'(ch) * SlotW'(Hd) + SlotW'(rd_pos);

	ccts_rate_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.window  (div_win),
		.elapsed (elapsed),
		.ctl     (div_ctl),
		.rate    (div_rate)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ccts_pkg::S_IDLE:
				if (in_acc)
					state_d = (in_item.req_type == ccts_pkg::REQ_TICK) ?
						ccts_pkg::S_DIV_RX : ccts_pkg::S_APPLY;
			ccts_pkg::S_DIV_RX:
				if (elapsed == '0 || div_ctl.done)
					state_d = ccts_pkg::S_DIV_TX;
			ccts_pkg::S_DIV_TX:
				if (elapsed == '0 || div_ctl.done)
					state_d = (tc_q == ChW'(Ch - 1)) ? ccts_pkg::S_APPLY
						: ccts_pkg::S_DIV_RX;
			ccts_pkg::S_APPLY: state_d = ccts_pkg::S_RING;
			ccts_pkg::S_RING:  state_d = ccts_pkg::S_OUT;
			ccts_pkg::S_OUT:
				if (!out_valid_q) state_d = ccts_pkg::S_IDLE;
			default: state_d = ccts_pkg::S_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		div_start = 1'b0;
		unique case (state_q)
			ccts_pkg::S_DIV_RX, ccts_pkg::S_DIV_TX:
				div_start = (elapsed != '0) && !div_ctl.busy && !div_ctl.done;
			default: div_start = 1'b0;
		endcase
	end

	always_comb begin
		res_d = '0;
		if (!ch_ok) begin
			res_d.status = ccts_pkg::ST_BAD_CH;
		end else begin
			res_d.recv_total   = rx_count_q[ch];
			res_d.recv_dropped = rx_drop_q[ch];
			res_d.send_total   = tx_count_q[ch];
			res_d.send_dropped = tx_drop_q[ch];
			res_d.recv_fps     = rx_rate_q[ch];
			res_d.send_fps     = tx_rate_q[ch];
			res_d.history_fill = 6'(fill_q[ch]);
			if (req_q.req_type == ccts_pkg::REQ_HIST) begin
				if (age_bad) begin
					res_d.status = ccts_pkg::ST_BAD_AGE;
				end else begin
					res_d.hist_header = rd_hdr_q;
					res_d.hist_data   = rd_dat_q;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ccts_pkg::S_IDLE;
			out_valid_q <= 1'b0;
			tc_q        <= '0;
			for (int i = 0; i < Ch; i++) begin
				rx_count_q[i]  <= '0;
				rx_drop_q[i]   <= '0;
				tx_count_q[i]  <= '0;
				tx_drop_q[i]   <= '0;
				rx_window_q[i] <= '0;
				tx_window_q[i] <= '0;
				rx_rate_q[i]   <= '0;
				tx_rate_q[i]   <= '0;
				stamp_q[i]     <= '0;
				wpos_q[i]      <= '0;
				fill_q[i]      <= '0;
			end
		end else begin
			state_q <= state_d;
			if (out_acc)
				out_valid_q <= 1'b0;
			if (state_q == ccts_pkg::S_IDLE)
				tc_q <= '0;
			if (state_q == ccts_pkg::S_DIV_RX && (elapsed == '0 || div_ctl.done)) begin
				if (elapsed != '0)
					rx_rate_q[tc_q] <= div_rate;
			end
			if (state_q == ccts_pkg::S_DIV_TX && (elapsed == '0 || div_ctl.done)) begin
				if (elapsed != '0)
					tx_rate_q[tc_q] <= div_rate;
				rx_window_q[tc_q] <= '0;
				tx_window_q[tc_q] <= '0;
				stamp_q[tc_q]     <= req_q.now_ms;
				tc_q              <= tc_q + 1'b1;
			end
			if (state_q == ccts_pkg::S_APPLY && ch_ok) begin
				case (req_q.req_type)
					ccts_pkg::REQ_RECV: begin
						rx_count_q[ch]  <= rx_count_q[ch] + 32'd1;
						rx_window_q[ch] <= rx_window_q[ch] + 32'd1;
						wpos_q[ch] <= (wpos_q[ch] == PosW'(Hd - 1)) ? '0
							: wpos_q[ch] + 1'b1;
						if (fill_q[ch] < FillW'(Hd))
							fill_q[ch] <= fill_q[ch] + 1'b1;
					end
					ccts_pkg::REQ_DROP_RX: rx_drop_q[ch] <= rx_drop_q[ch] + req_q.drop_amount;
					ccts_pkg::REQ_SEND: begin
						tx_count_q[ch]  <= tx_count_q[ch] + 32'd1;
						tx_window_q[ch] <= tx_window_q[ch] + 32'd1;
					end
					ccts_pkg::REQ_DROP_TX: tx_drop_q[ch] <= tx_drop_q[ch] + 32'd1;
					default: ;
				endcase
			end
			if (state_q == ccts_pkg::S_RING)
				out_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc)
			req_q <= in_item;
		if (state_q == ccts_pkg::S_APPLY && ch_ok
			&& req_q.req_type == ccts_pkg::REQ_RECV) begin
			ring_hdr_q[wr_slot] <= req_q.msg_header;
			ring_dat_q[wr_slot] <= req_q.msg_data;
		end
		if (state_q == ccts_pkg::S_APPLY) begin
			rd_hdr_q <= ring_hdr_q[rd_slot];
			rd_dat_q <= ring_dat_q[rd_slot];
		end
		if (state_q == ccts_pkg::S_RING)
			res_q <= res_d;
	end
endmodule

// ===== rtl/core/ccts_rate_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccts_rate_div: serial rate divider
// Computes min(floor(window*1000/elapsed), max rate), one quotient bit per
// cycle with a restoring subtract.
// ----------------------------------------------------------------------------
module ccts_rate_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [31:0]               window,
	input  logic [31:0]               elapsed,
	output ccts_pkg::div_ctl_t        ctl,
	output logic [ccts_pkg::RateW-1:0] rate
);
	localparam int NumW = 42;
	localparam int CntW = $clog2(NumW + 1);

	logic [NumW-1:0] num_q;
	logic [NumW-1:0] quo_q;
	logic [32:0]     rem_q;
	logic [31:0]     den_q;
	logic [CntW-1:0] cnt_q;
	logic            busy_q;
	logic            done_q;
	logic [32:0]     shifted;
	logic [33:0]     diff;

	assign shifted = {rem_q[31:0], num_q[NumW-1]};
	assign diff    = {1'b0, shifted} - {2'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CntW'(NumW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CntW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= NumW'(window * 42'(ccts_pkg::MsPerSec));
			den_q <= elapsed;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[NumW-2:0], 1'b0};
			if (!diff[33]) begin
				rem_q <= diff[32:0];
				quo_q <= {quo_q[NumW-2:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[NumW-2:0], 1'b0};
			end
		end
	end

	assign ctl.start = start;
	assign ctl.busy  = busy_q;
	assign ctl.done  = done_q;
	assign rate = (|quo_q[NumW-1:ccts_pkg::RateW]) ? ccts_pkg::RateMax
		: quo_q[ccts_pkg::RateW-1:0];
endmodule

// ===== tb/sv/ccts_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccts_checker: result predictor and comparator
// Watches both item channels of the traffic statistics block, predicts each
// result from its own copy of the per-channel counters, rates and history
// rings, and compares every result field by field in order.
// ----------------------------------------------------------------------------
module ccts_checker
	import ccts_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      in_stall,
	input  in_item_t  in_item,
	input  logic      out_valid,
	input  logic      out_stall,
	input  out_item_t out_item,
	output int        fail_count,
	output int        pending,
	output int        results_seen
);

	logic [31:0] rx_tot [Channels];
	logic [31:0] rx_drp [Channels];
	logic [31:0] tx_tot [Channels];
	logic [31:0] tx_drp [Channels];
	logic [31:0] rx_win [Channels];
	logic [31:0] tx_win [Channels];
	logic [19:0] rx_fps [Channels];
	logic [19:0] tx_fps [Channels];
	logic [31:0] stamp  [Channels];
	logic [31:0] hist_h [Channels][HistoryDepth];
	logic [63:0] hist_d [Channels][HistoryDepth];
	int          wpos   [Channels];
	int          fill   [Channels];
	out_item_t   expected_results [$];

	function automatic logic [19:0] fps_of(logic [31:0] win, logic [31:0] el);
		logic [63:0] q;
		q = ({32'd0, win} * 64'd1000) / {32'd0, el};
		return (q > 64'hFFFFF) ? 20'hFFFFF : q[19:0];
	endfunction

	function automatic out_item_t predict_stats(in_item_t it);
		out_item_t r;
		int c;
		int p;
		logic [31:0] el;
		r = '0;
		if (it.req_type == REQ_TICK) begin
			for (c = 0; c < Channels; c++) begin
				el = it.now_ms - stamp[c];
				if (el != 0) begin
					rx_fps[c] = fps_of(rx_win[c], el);
					tx_fps[c] = fps_of(tx_win[c], el);
				end
				rx_win[c] = '0;
				tx_win[c] = '0;
				stamp[c] = it.now_ms;
			end
		end
		if (it.channel >= Channels) begin
			r.status = ST_BAD_CH;
			return r;
		end
		c = it.channel;
		r.status = ST_OK;
		case (req_t'(it.req_type))
			REQ_RECV: begin
				rx_tot[c]++;
				rx_win[c]++;
				hist_h[c][wpos[c]] = it.msg_header;
				hist_d[c][wpos[c]] = it.msg_data;
				wpos[c] = (wpos[c] + 1) % HistoryDepth;
				if (fill[c] < HistoryDepth) fill[c]++;
			end
			REQ_DROP_RX: rx_drp[c] += it.drop_amount;
			REQ_SEND: begin
				tx_tot[c]++;
				tx_win[c]++;
			end
			REQ_DROP_TX: tx_drp[c]++;
			REQ_HIST: begin
				if (it.history_age >= fill[c] || it.history_age >= HistoryDepth) begin
					r.status = ST_BAD_AGE;
				end else begin
					p = (wpos[c] + HistoryDepth - 1 - it.history_age) % HistoryDepth;
					r.hist_header = hist_h[c][p];
					r.hist_data = hist_d[c][p];
				end
			end
			default: ;
		endcase
		r.recv_total = rx_tot[c];
		r.recv_dropped = rx_drp[c];
		r.send_total = tx_tot[c];
		r.send_dropped = tx_drp[c];
		r.recv_fps = rx_fps[c];
		r.send_fps = tx_fps[c];
		r.history_fill = 6'(fill[c]);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_item_t e;
		if (!arst_n) begin
			for (int c = 0; c < Channels; c++) begin
				rx_tot[c] = '0; rx_drp[c] = '0; tx_tot[c] = '0; tx_drp[c] = '0;
				rx_win[c] = '0; tx_win[c] = '0; rx_fps[c] = '0; tx_fps[c] = '0;
				stamp[c] = '0; wpos[c] = 0; fill[c] = 0;
			end
			expected_results.delete();
			fail_count = 0;
			pending = 0;
			results_seen = 0;
		end else begin
			if (in_valid && !in_stall)
				expected_results.push_back(predict_stats(in_item));
			if (out_valid && !out_stall) begin
				results_seen++;
				if (expected_results.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result %h", out_item);
				end else begin
					e = expected_results.pop_front();
					if (e !== out_item) begin
						fail_count++;
						if (fail_count <= 10) begin
							$display({"mismatch: exp st=%0d rx=%h rd=%h tx=%h td=%h",
								" rf=%h tf=%h fl=%0d hh=%h hd=%h"},
								e.status, e.recv_total, e.recv_dropped, e.send_total,
								e.send_dropped, e.recv_fps, e.send_fps, e.history_fill,
								e.hist_header, e.hist_data);
							$display({"          act st=%0d rx=%h rd=%h tx=%h td=%h",
								" rf=%h tf=%h fl=%0d hh=%h hd=%h"},
								out_item.status, out_item.recv_total, out_item.recv_dropped,
								out_item.send_total, out_item.send_dropped, out_item.recv_fps,
								out_item.send_fps, out_item.history_fill, out_item.hist_header,
								out_item.hist_data);
						end
					end
				end
			end
			pending = expected_results.size();
		end
	end

endmodule

// ===== tb/sv/tb_can_channel_traffic_stats.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_can_channel_traffic_stats: testbench top
// Drives directed and random request items into the traffic statistics
// block under three idling mixes and one long output hold-off; the checker
// predicts and compares each result.
// ----------------------------------------------------------------------------
module tb_can_channel_traffic_stats;
	import ccts_pkg::*;

	localparam int WatchdogLimit = 20000;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_stall;
	in_item_t  in_item;
	logic      out_valid;
	logic      out_stall;
	out_item_t out_item;
	int        fail_count;
	int        pending;
	int        results_seen;
	int        src_idle;
	int        snk_idle;
	bit        hold_off;
	int        idle_cycles;
	int        items_sent;
	int        ticks_sent;

	can_channel_traffic_stats uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
		.out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
	);

	ccts_checker chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
		.out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
		.fail_count(fail_count), .pending(pending), .results_seen(results_seen)
	);

	always begin
		clk = 1'b1; #6;
		clk = 1'b0; #6;
	end

	// receiver stall, with a long hold-off on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (hold_off) begin
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < snk_idle);
		end
	end

	always @(posedge clk) begin
		if (arst_n && !((in_valid && !in_stall) || (out_valid && !out_stall)))
			idle_cycles <= idle_cycles + 1;
		else
			idle_cycles <= 0;
	end

	always @(posedge clk) begin
		if (idle_cycles >= WatchdogLimit) begin
			$display("tb: failure");
			$finish;
		end
	end

	function automatic in_item_t rand_item();
		in_item_t it;
		int r;
		it.msg_header = $urandom;
		it.msg_data = {$urandom, $urandom};
		it.drop_amount = ($urandom_range(3) == 0) ? $urandom : $urandom_range(20);
		it.now_ms = $urandom;
		it.history_age = 6'(($urandom_range(3) == 0) ? $urandom_range(63)
			: $urandom_range(11));
		it.channel = 4'(($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(3));
		r = $urandom_range(99);
		if (r < 35) it.req_type = REQ_RECV;
		else if (r < 45) it.req_type = REQ_DROP_RX;
		else if (r < 65) it.req_type = REQ_SEND;
		else if (r < 70) it.req_type = REQ_DROP_TX;
		else if (r < 75) it.req_type = REQ_TICK;
		else if (r < 82) it.req_type = REQ_READ;
		else if (r < 97) it.req_type = REQ_HIST;
		else it.req_type = REQ_NONE;
		return it;
	endfunction

	task automatic send_item(in_item_t it);
		while ($urandom_range(99) < src_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_item <= it;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		items_sent++;
		if (it.req_type == REQ_TICK) ticks_sent++;
	endtask

	task automatic make_item(output in_item_t it, input req_t rq, input int ch,
			input logic [31:0] tm, input int age);
		it = rand_item();
		it.req_type = rq;
		it.channel = 4'(ch);
		it.now_ms = tm;
		it.history_age = 6'(age);
	endtask

	task automatic drain();
		while (pending != 0) @(posedge clk);
		in_valid <= 1'b0;
	endtask

	initial begin
		in_item_t it;
		logic [31:0] clock_ms;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_item = '0;
		hold_off = 1'b0;
		src_idle = 0;
		snk_idle = 0;
		items_sent = 0;
		ticks_sent = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty history, extremes, every code, bad channels
		make_item(it, REQ_HIST, 0, 0, 0);        send_item(it);
		make_item(it, REQ_TICK, 0, 0, 0);        send_item(it);
		make_item(it, REQ_RECV, 0, 0, 0);
		it.msg_header = '1; it.msg_data = '1;    send_item(it);
		make_item(it, REQ_RECV, 0, 0, 0);
		it.msg_header = '0; it.msg_data = '0;    send_item(it);
		make_item(it, REQ_HIST, 0, 0, 1);        send_item(it);
		make_item(it, REQ_HIST, 0, 0, 2);        send_item(it);
		make_item(it, REQ_HIST, 0, 0, 63);       send_item(it);
		make_item(it, REQ_DROP_RX, 1, 0, 0);
		it.drop_amount = '1;                     send_item(it);
		make_item(it, REQ_DROP_RX, 1, 0, 0);
		it.drop_amount = 32'd2;                  send_item(it);
		make_item(it, REQ_SEND, 3, 0, 0);        send_item(it);
		make_item(it, REQ_DROP_TX, 3, 0, 0);     send_item(it);
		make_item(it, REQ_READ, 3, 0, 0);        send_item(it);
		make_item(it, REQ_NONE, 2, 0, 0);        send_item(it);
		make_item(it, REQ_RECV, 15, 0, 0);       send_item(it);
		make_item(it, REQ_HIST, 4, 0, 0);        send_item(it);
		make_item(it, REQ_TICK, 15, 32'd1, 0);   send_item(it);
		for (int i = 0; i < 4; i++) begin
			make_item(it, REQ_RECV, 2, 0, 0);    send_item(it);
		end
		make_item(it, REQ_TICK, 2, 32'd1, 0);    send_item(it);
		make_item(it, REQ_SEND, 2, 0, 0);        send_item(it);
		make_item(it, REQ_TICK, 2, '1, 0);       send_item(it);
		make_item(it, REQ_TICK, 2, 32'd0, 0);    send_item(it);
		for (int i = 0; i < 12; i++) begin
			make_item(it, REQ_RECV, 1, 0, 0);    send_item(it);
		end
		make_item(it, REQ_HIST, 1, 0, 9);        send_item(it);
		make_item(it, REQ_HIST, 1, 0, 10);       send_item(it);
		drain();

		// long output hold-off while input keeps offering
		hold_off = 1'b1;
		fork
			begin
				repeat (400) @(posedge clk);
				hold_off = 1'b0;
			end
			for (int i = 0; i < 6; i++) begin
				make_item(it, REQ_SEND, 0, 0, 0);
				send_item(it);
			end
		join
		drain();

		clock_ms = 32'd100;
		for (int ph = 0; ph < 3; ph++) begin
			src_idle = (ph == 0) ? 16 : (ph == 1) ? 78 : 0;
			snk_idle = (ph == 0) ? 78 : (ph == 1) ? 16 : 0;
			for (int i = 0; i < 600; i++) begin
				it = rand_item();
				if (it.req_type == REQ_TICK && $urandom_range(4) != 0) begin
					clock_ms += $urandom_range(3) == 0 ? 0 : $urandom_range(2000);
					it.now_ms = clock_ms;
				end
				send_item(it);
			end
		end
		drain();
		repeat (500) @(posedge clk);
		$display("ran %0d items (%0d rate ticks), %0d results checked, %0d mismatches",
			items_sent, ticks_sent, results_seen, fail_count);
		if (fail_count == 0 && pending == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
